[rtl/bcp_pkg.sv]
// Shared types and constants for the bracketed command line parser.
// No dependencies; imported by bcp_core and bracketed_command_line_parser.
package bcp_pkg;

    localparam int LINE_MAX  = 4096;
    localparam int FIELD_MAX = 32;
    localparam int LINE_W    = $clog2(LINE_MAX + 1);
    localparam int FLEN_W    = $clog2(FIELD_MAX);
    localparam int DEPTH_W   = 13;
    localparam int MIN_LINE  = 5;

    localparam logic [DEPTH_W-1:0] DEPTH_MAX = {DEPTH_W{1'b1}};
    localparam logic [LINE_W-1:0]  LINE_LIM  = LINE_W'(LINE_MAX - 1);
    localparam logic [LINE_W-1:0]  LINE_SAT  = LINE_W'(LINE_MAX);
    localparam logic [LINE_W-1:0]  LINE_MIN  = LINE_W'(MIN_LINE);
    localparam logic [FLEN_W-1:0]  FIELD_LIM = FLEN_W'(FIELD_MAX - 1);

    localparam logic [7:0] CH_ANGLE  = 8'h3C;
    localparam logic [7:0] CH_DOT    = 8'h2E;
    localparam logic [7:0] CH_OPEN   = 8'h28;
    localparam logic [7:0] CH_CLOSE  = 8'h29;
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_LOW_A  = 8'h61;
    localparam logic [7:0] CH_LOW_Z  = 8'h7A;
    localparam logic [7:0] CASE_GAP  = 8'd32;

    localparam logic [1:0] CNT_INVALID = 2'd0;
    localparam logic [1:0] CNT_ACTOR   = 2'd1;
    localparam logic [1:0] CNT_FULL    = 2'd3;

    typedef enum logic [1:0] {
        ACT_IDLE,
        ACT_IN,
        ACT_DONE
    } t_act_ph;

    typedef enum logic [1:0] {
        CMD_IDLE,
        CMD_SKIP,
        CMD_IN,
        CMD_DONE
    } t_cmd_ph;

    typedef enum logic [1:0] {
        PAY_IDLE,
        PAY_IN,
        PAY_DONE
    } t_pay_ph;

    typedef struct packed {
        logic               seen_angle;
        t_act_ph            act_ph;
        logic [FLEN_W-1:0]  act_len;
        t_cmd_ph            cmd_ph;
        logic [FLEN_W-1:0]  cmd_len;
        t_pay_ph            pay_ph;
        logic [DEPTH_W-1:0] depth;
        logic               quoted;
        logic               bs_odd;
        logic [LINE_W-1:0]  line_len;
        logic               truncated;
    } t_state;

    typedef struct packed {
        logic [7:0] byte_out;
        logic       in_actor;
        logic       in_command;
        logic       in_payload;
        logic       done_res;
        logic [1:0] arg_count;
        logic       overflow;
    } t_result;

endpackage

[rtl/bcp_core.sv]
// Parser state registers and the per-byte next-state and result logic.
// Depends on bcp_pkg.
module bcp_core (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_advance,
    input  logic [7:0]       i_byte,
    input  logic             i_last,
    output bcp_pkg::t_result o_res
);
    import bcp_pkg::*;

    t_state  r_st;
    t_state  n_st;
    t_result w_res;

    always_comb begin
        logic [7:0] b;
        logic       ia;
        logic       ic;
        logic       ip;
        logic       act;
        b     = i_byte;
        ia    = 1'b0;
        ic    = 1'b0;
        ip    = 1'b0;
        act   = 1'b0;
        n_st  = r_st;
        w_res = '0;

        if (r_st.line_len >= LINE_LIM) begin
            n_st.truncated = 1'b1;
        end else begin
            // command phase moves first, on the phase before this byte
            case (r_st.cmd_ph)
                CMD_SKIP: if (b != CH_OPEN) n_st.cmd_ph = CMD_IN;
                CMD_IN:   if (b == CH_OPEN) n_st.cmd_ph = CMD_DONE;
                default:  ;
            endcase
            if (n_st.cmd_ph == CMD_IN) begin
                if (r_st.cmd_len < FIELD_LIM) begin
                    ic = 1'b1;
                    n_st.cmd_len = r_st.cmd_len + 1'b1;
                end else begin
                    n_st.truncated = 1'b1;
                end
            end

            if (r_st.act_ph == ACT_IDLE && b == CH_ANGLE) begin
                n_st.act_ph     = ACT_IN;
                n_st.seen_angle = 1'b1;
                act             = 1'b1;
            end else if (r_st.act_ph == ACT_IN) begin
                if (b == CH_DOT) begin
                    n_st.act_ph = ACT_DONE;
                    n_st.cmd_ph = CMD_SKIP;
                end else begin
                    act = 1'b1;
                end
            end
            if (act) begin
                if (r_st.act_len < FIELD_LIM) begin
                    ia = 1'b1;
                    n_st.act_len = r_st.act_len + 1'b1;
                end else begin
                    n_st.truncated = 1'b1;
                end
            end

            case (r_st.pay_ph)
                PAY_IDLE: begin
                    if (r_st.seen_angle && b == CH_OPEN) begin
                        n_st.pay_ph = PAY_IN;
                        n_st.depth  = DEPTH_W'(1);
                        n_st.quoted = 1'b0;
                        n_st.bs_odd = 1'b0;
                    end
                end
                PAY_IN: begin
                    ip = 1'b1;
                    if (b == CH_QUOTE) begin
                        if (!r_st.bs_odd) n_st.quoted = ~r_st.quoted;
                        n_st.bs_odd = 1'b0;
                    end else begin
                        n_st.bs_odd = (b == CH_BSLASH) ? ~r_st.bs_odd : 1'b0;
                        if (!r_st.quoted) begin
                            if (b == CH_OPEN) begin
                                if (r_st.depth < DEPTH_MAX) n_st.depth = r_st.depth + 1'b1;
                            end else if (b == CH_CLOSE) begin
                                if (r_st.depth != '0) n_st.depth = r_st.depth - 1'b1;
                                if (n_st.depth == '0) begin
                                    n_st.pay_ph = PAY_DONE;
                                    ip          = 1'b0;
                                end
                            end
                        end
                    end
                end
                default: ;
            endcase
        end

        if (r_st.line_len < LINE_SAT) n_st.line_len = r_st.line_len + 1'b1;

        if ((ia || ic) && b >= CH_LOW_A && b <= CH_LOW_Z) b = b - CASE_GAP;

        w_res.byte_out   = b;
        w_res.in_actor   = ia;
        w_res.in_command = ic;
        w_res.in_payload = ip;
        w_res.done_res   = i_last;
        if (i_last) begin
            if (n_st.line_len >= LINE_MIN && n_st.seen_angle && n_st.pay_ph == PAY_DONE) begin
                w_res.arg_count = (n_st.cmd_ph == CMD_IN || n_st.cmd_ph == CMD_DONE)
                                  ? CNT_FULL : CNT_ACTOR;
            end else begin
                w_res.arg_count = CNT_INVALID;
            end
            w_res.overflow = n_st.truncated;
            n_st = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= '0;
        end else if (i_advance) begin
            r_st <= n_st;
        end
    end

    assign o_res = w_res;

    // actor and command never claim the same byte
    a_field_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_advance && w_res.in_actor && w_res.in_command))
        else $error("actor and command flags both set");

    // the end of a line returns the parser to its idle state
    a_line_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_advance && i_last) |=> (r_st.line_len == '0 && !r_st.seen_angle))
        else $error("state not cleared after line end");

    // summary fields stay zero except on the final byte
    a_summary_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_advance && !i_last) |-> (w_res.arg_count == CNT_INVALID && !w_res.overflow))
        else $error("summary reported before line end");

endmodule

[rtl/bracketed_command_line_parser.sv]
// A request accepted into the input register is valid on the output once it moves into the output register.
// Throughput: one byte per cycle; the input register feeds the parser logic,
// whose result lands in the output register; input ready drops only when both
// registers are full and the sink stalls.
// Reset (synchronous, i_rst_n low) empties both registers and returns the parser
// to the start of a line; no clearing pass is needed.
// Top level of the bracketed command line parser; depends on bcp_pkg, bcp_core.
module bracketed_command_line_parser (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [7:0]  i_s_axis_tdata,  // [7:0] byte_in
    input  logic        i_s_axis_tlast,  // line_end
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [15:0] o_m_axis_tdata,  // [7:0] byte_out, [8] in_actor, [9] in_command,
                                         // [10] in_payload, [12:11] arg_count,
                                         // [13] overflow, [15:14] zero
    output logic        o_m_axis_tlast   // done_res
);
    import bcp_pkg::*;

    logic       r_in_valid;
    logic [7:0] r_in_byte;
    logic       r_in_last;
    logic       r_out_valid;
    t_result    r_res;
    t_result    w_res;
    logic       w_adv;
    logic       w_take;

    assign w_adv           = r_in_valid && (!r_out_valid || i_m_axis_tready);
    assign o_s_axis_tready = !r_in_valid || w_adv;
    assign w_take          = i_s_axis_tvalid && o_s_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (w_take) begin
            r_in_valid <= 1'b1;
        end else if (w_adv) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_in_byte <= i_s_axis_tdata;
            r_in_last <= i_s_axis_tlast;
        end
    end

    bcp_core u_core (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_advance (w_adv),
        .i_byte    (r_in_byte),
        .i_last    (r_in_last),
        .o_res     (w_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_adv) begin
            r_out_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_res <= w_res;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {2'b00, r_res.overflow, r_res.arg_count, r_res.in_payload,
                              r_res.in_command, r_res.in_actor, r_res.byte_out};
    assign o_m_axis_tlast  = r_res.done_res;

    // input side only blocks when both registers hold data and the sink stalls
    a_ready_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_s_axis_tready |-> (r_in_valid && r_out_valid && !i_m_axis_tready))
        else $error("input stalled without a full pipeline");

    // a request moved into the output register shows up as valid next cycle
    a_adv_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_adv |=> o_m_axis_tvalid)
        else $error("advanced result not presented");

    // a result only leaves the input register when one was held there
    a_adv_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_adv |-> r_in_valid)
        else $error("advance without a held request");

endmodule
